[hw/rtl/utra_pkg.sv]
// utra_pkg: shared widths, ascii constants and digit mapping for the
// unsigned-to-radix ascii converter and its iterative divider
// no dependencies
package utra_pkg;

    // default number of value bits converted
    localparam int VALUE_BITS_DEF = 32;

    // fixed port widths
    localparam int VALUE_WIDTH = 32;
    localparam int RADIX_WIDTH = 6;
    localparam int CHAR_WIDTH  = 7;
    localparam int COUNT_WIDTH = 6;

    // quotient bits resolved by the divider per clock
    localparam int DIV_BITS_PER_CYCLE = 4;

    // legal radix range, values outside are clamped
    localparam logic [RADIX_WIDTH-1:0] RADIX_MIN = 6'd2;
    localparam logic [RADIX_WIDTH-1:0] RADIX_MAX = 6'd36;

    // ascii mapping
    localparam logic [CHAR_WIDTH-1:0]  ASCII_ZERO = 7'h30;
    localparam logic [CHAR_WIDTH-1:0]  ALPHA_SKIP = 7'd7;
    localparam logic [RADIX_WIDTH-1:0] DEC_BASE   = 6'd10;

    typedef logic [RADIX_WIDTH-1:0] t_digit;
    typedef logic [CHAR_WIDTH-1:0]  t_char;

    // digit 0..35 to '0'..'9', 'A'..'Z'
    function automatic t_char digit_to_ascii(input t_digit d);
        t_char c;
        c = {1'b0, d} + ASCII_ZERO;
        if (d >= DEC_BASE) begin
            c = c + ALPHA_SKIP;
        end
        return c;
    endfunction

endpackage

[hw/rtl/unsigned_to_radix_ascii.sv]
// unsigned_to_radix_ascii: converts an unsigned value to ascii digits in
// radix 2..36, most significant digit first
// depends on utra_pkg and utra_div
//
// usage:
//   a request is taken at a clock edge with start high and busy low; it
//   carries i_value (low VALUE_BITS bits used) and i_radix (0..1 act as 2,
//   37..63 act as 36). busy stays high until the final digit is issued.
//   each digit appears on o_character for one cycle with o_strobe high,
//   most significant first; o_is_last marks the final digit and every
//   digit carries o_digit_count. a zero value gives the single digit '0'.
//   the receiver cannot stall: digits come out on consecutive cycles.
// operation, for n digits:
//   each digit is one pass of the shared divider, whose remainder is
//   then stored; all n digits are collected first, then streamed out
//   through the output register.
//   a new request may be taken in the cycle that shows the final digit.
// reset: synchronous, active low; sequencer to idle, no strobe, no
//   memory clearing needed
module unsigned_to_radix_ascii #(
    parameter int VALUE_BITS = utra_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             start,
    output logic                             busy,
    input  logic [utra_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic [utra_pkg::RADIX_WIDTH-1:0] i_radix,
    output logic                             o_strobe,
    output logic [utra_pkg::CHAR_WIDTH-1:0]  o_character,
    output logic                             o_is_last,
    output logic [utra_pkg::COUNT_WIDTH-1:0] o_digit_count
);

    // working width, the port carries at most VALUE_WIDTH bits
    localparam int W   = (VALUE_BITS < utra_pkg::VALUE_WIDTH) ?
                         VALUE_BITS : utra_pkg::VALUE_WIDTH;
    localparam int BPC = utra_pkg::DIV_BITS_PER_CYCLE;
    // divider width padded to whole quotient-bit groups
    localparam int WP  = ((W + BPC - 1) / BPC) * BPC;
    localparam int CW  = $clog2(W + 1);   // digit counter, holds W itself
    localparam int IW  = $clog2(W);       // digit store index
    localparam int RW  = utra_pkg::RADIX_WIDTH;
    localparam int OCW = utra_pkg::COUNT_WIDTH;

    // sequencer states
    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_EMIT = 2'd2;

    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count, n_count;   // digits collected
    logic [CW-1:0] r_idx, n_idx;       // digits still to stream
    logic [RW-1:0] r_radix;

    // digit store, least significant digit at index zero
    utra_pkg::t_digit r_digits [W];

    // registered result
    logic                   r_strobe, n_strobe;
    utra_pkg::t_char        r_char;
    logic                   r_last;
    logic [OCW-1:0]         r_dcount;

    // divider hookup
    logic          accept;
    logic          div_start;
    logic [WP-1:0] div_dividend;
    logic [RW-1:0] div_divisor;
    logic          div_done;
    logic [WP-1:0] div_quotient;
    logic [RW-1:0] div_remainder;
    logic          more_digits;
    logic [RW-1:0] radix_clamped;
    logic [CW-1:0] rd_sel;

    assign accept = start && (r_state == ST_IDLE);
    assign busy   = (r_state != ST_IDLE);

    // out-of-range radix folds to the nearest legal one
    always_comb begin
        priority if (i_radix < utra_pkg::RADIX_MIN) begin
            radix_clamped = utra_pkg::RADIX_MIN;
        end else if (i_radix > utra_pkg::RADIX_MAX) begin
            radix_clamped = utra_pkg::RADIX_MAX;
        end else begin
            radix_clamped = i_radix;
        end
    end

    // quotient nonzero means another digit follows
    assign more_digits = (div_quotient != '0);

    // the divider is launched on a new request or straight after a pass
    // whose quotient still has digits left
    assign div_start    = accept || ((r_state == ST_DIV) && div_done && more_digits);
    assign div_dividend = accept ? WP'(i_value[W-1:0]) : div_quotient;
    assign div_divisor  = accept ? radix_clamped : r_radix;

    utra_div #(
        .DW (WP)
    ) u_div (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (div_start),
        .i_dividend  (div_dividend),
        .i_divisor   (div_divisor),
        .o_done      (div_done),
        .o_quotient  (div_quotient),
        .o_remainder (div_remainder)
    );

    // read pointer, most significant stored digit first
    assign rd_sel = r_idx - 1'b1;

    always_comb begin
        n_state  = r_state;
        n_count  = r_count;
        n_idx    = r_idx;
        n_strobe = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_DIV;
                    n_count = '0;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    n_count = r_count + 1'b1;
                    if (!more_digits) begin
                        n_state = ST_EMIT;
                        n_idx   = r_count + 1'b1;
                    end
                end
            end
            ST_EMIT: begin
                n_strobe = 1'b1;
                n_idx    = r_idx - 1'b1;
                if (r_idx == CW'(1)) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_count  <= '0;
            r_idx    <= '0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_idx    <= n_idx;
            r_strobe <= n_strobe;
        end
    end

    // radix held for the whole request
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_radix <= radix_clamped;
        end
    end

    // store each remainder as it comes out of the divider
    always_ff @(posedge i_clk) begin
        if ((r_state == ST_DIV) && div_done) begin
            r_digits[r_count[IW-1:0]] <= div_remainder;
        end
    end

    // result register, payload needs no reset
    always_ff @(posedge i_clk) begin
        if (r_state == ST_EMIT) begin
            r_char   <= utra_pkg::digit_to_ascii(r_digits[rd_sel[IW-1:0]]);
            r_last   <= (r_idx == CW'(1));
            r_dcount <= OCW'(r_count);
        end
    end

    assign o_strobe      = r_strobe;
    assign o_character   = r_char;
    assign o_is_last     = r_last;
    assign o_digit_count = r_dcount;

    // digits of one request stream without gaps
    a_no_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && !o_is_last |=> o_strobe)
        else $error("gap inside digit stream");

    // the final digit ends the stream
    a_last_ends: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe && o_is_last |=> !o_strobe)
        else $error("strobe after final digit");

    // digit count within the value width
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (o_digit_count != '0) && (o_digit_count <= OCW'(W)))
        else $error("digit count out of range");

    // divider results only arrive while collecting digits
    a_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == ST_DIV))
        else $error("divider done outside collect phase");

    // digit store never overruns
    a_store_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_DIV) && div_done |-> (r_count < CW'(W)))
        else $error("digit store overrun");

endmodule

[hw/rtl/utra_div.sv]
// utra_div: iterative restoring divider, wide dividend by a small radix,
// several quotient bits per clock
// depends on utra_pkg
module utra_div #(
    parameter int DW = utra_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic [DW-1:0]                    i_dividend,
    input  logic [utra_pkg::RADIX_WIDTH-1:0] i_divisor,
    output logic                             o_done,
    output logic [DW-1:0]                    o_quotient,
    output logic [utra_pkg::RADIX_WIDTH-1:0] o_remainder
);

    localparam int BPC   = utra_pkg::DIV_BITS_PER_CYCLE;
    localparam int RW    = utra_pkg::RADIX_WIDTH;
    localparam int STEPS = DW / BPC;
    localparam int SW    = $clog2(STEPS + 1);

    logic [DW-1:0] r_work, n_work;
    logic [RW-1:0] r_rem, n_rem;
    logic [RW-1:0] r_div;
    logic [SW-1:0] r_cnt;
    logic          r_done;

    // one clock of shift-subtract, BPC dependent narrow steps
    always_comb begin
        logic [RW:0]   t;
        logic [DW-1:0] w;
        logic [RW-1:0] rm;
        w  = r_work;
        rm = r_rem;
        t  = '0;
        for (int j = 0; j < BPC; j++) begin
            t = {rm, w[DW-1]};
            w = {w[DW-2:0], 1'b0};
            if (t >= {1'b0, r_div}) begin
                t    = t - {1'b0, r_div};
                w[0] = 1'b1;
            end
            rm = t[RW-1:0];
        end
        n_work = w;
        n_rem  = rm;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else if (i_start) begin
            r_cnt  <= SW'(STEPS);
            r_done <= 1'b0;
        end else if (r_cnt != '0) begin
            r_cnt  <= r_cnt - 1'b1;
            r_done <= (r_cnt == SW'(1));
        end else begin
            r_done <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_work <= i_dividend;
            r_rem  <= '0;
            r_div  <= i_divisor;
        end else if (r_cnt != '0) begin
            r_work <= n_work;
            r_rem  <= n_rem;
        end
    end

    assign o_done      = r_done;
    assign o_quotient  = r_work;
    assign o_remainder = r_rem;

endmodule

[dv/utra_digit_checker.sv]
// digit_stream_checker: watches the request and digit channels of
// unsigned_to_radix_ascii, predicts the ascii digit stream and compares it
// depends on utra_pkg for port widths and ascii constants
module digit_stream_checker #(
    parameter int VALUE_BITS = utra_pkg::VALUE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_start,
    input  logic                             i_busy,
    input  logic [utra_pkg::VALUE_WIDTH-1:0] i_value,
    input  logic [utra_pkg::RADIX_WIDTH-1:0] i_radix,
    input  logic                             i_strobe,
    input  logic [utra_pkg::CHAR_WIDTH-1:0]  i_character,
    input  logic                             i_is_last,
    input  logic [utra_pkg::COUNT_WIDTH-1:0] i_digit_count,
    output int                               o_fail_count,
    output int                               o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam utra_pkg::t_char ASCII_UPPER_A = 7'h41;

    typedef struct {
        utra_pkg::t_char                  character;
        logic                             is_last;
        logic [utra_pkg::COUNT_WIDTH-1:0] digit_count;
    } t_expect;

    t_expect digit_queue[$];
    int      mismatches = 0;

    // queue the ascii digits of one request, most significant first
    function automatic void predict_digits(
        input logic [utra_pkg::VALUE_WIDTH-1:0] value,
        input logic [utra_pkg::RADIX_WIDTH-1:0] radix
    );
        logic [63:0] rest;
        int unsigned base;
        int unsigned digits[$];
        int          n;
        t_expect     d;
        rest = {32'b0, value};
        if (VALUE_BITS < 32) begin
            rest = rest & ((64'd1 << VALUE_BITS) - 64'd1);
        end
        // out-of-range radix saturates to the nearest legal base
        if (radix < utra_pkg::RADIX_MIN) begin
            base = 32'(utra_pkg::RADIX_MIN);
        end else if (radix > utra_pkg::RADIX_MAX) begin
            base = 32'(utra_pkg::RADIX_MAX);
        end else begin
            base = 32'(radix);
        end
        do begin
            digits.push_front(int'(rest % base));
            rest = rest / base;
        end while (rest != 0);
        n = digits.size();
        foreach (digits[k]) begin
            if (digits[k] < 10) begin
                d.character = utra_pkg::t_char'(utra_pkg::ASCII_ZERO + digits[k]);
            end else begin
                d.character = utra_pkg::t_char'(ASCII_UPPER_A + digits[k] - 10);
            end
            d.is_last     = (k == n - 1);
            d.digit_count = n[utra_pkg::COUNT_WIDTH-1:0];
            digit_queue.push_back(d);
        end
    endfunction

    always @(posedge i_clk) begin : watch_channels
        t_expect want;
        if (i_rst_n) begin
            if (i_strobe) begin
                if (digit_queue.size() == 0) begin
                    $error("unexpected digit %0h with no request outstanding", i_character);
                    mismatches++;
                end else begin
                    want = digit_queue.pop_front();
                    if (i_character !== want.character) begin
                        $error("character expected %0h actual %0h",
                               want.character, i_character);
                        mismatches++;
                    end
                    if (i_is_last !== want.is_last) begin
                        $error("is_last expected %0b actual %0b", want.is_last, i_is_last);
                        mismatches++;
                    end
                    if (i_digit_count !== want.digit_count) begin
                        $error("digit_count expected %0d actual %0d",
                               want.digit_count, i_digit_count);
                        mismatches++;
                    end
                end
            end
            if (i_start && !i_busy) begin
                predict_digits(i_value, i_radix);
            end
        end
        o_pending    <= digit_queue.size();
        o_fail_count <= mismatches;
    end

endmodule

[dv/tb_unsigned_to_radix_ascii.sv]
// tb_unsigned_to_radix_ascii: stimulus and verdict for unsigned_to_radix_ascii
// depends on utra_pkg, unsigned_to_radix_ascii and digit_stream_checker
module tb_unsigned_to_radix_ascii;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int VW  = utra_pkg::VALUE_WIDTH;
    localparam int RW  = utra_pkg::RADIX_WIDTH;
    localparam int CHW = utra_pkg::CHAR_WIDTH;
    localparam int DCW = utra_pkg::COUNT_WIDTH;

    localparam int RANDOM_REQUESTS = 180;

    logic           i_clk;
    logic           i_rst_n;
    logic           start;
    logic           busy;
    logic [VW-1:0]  i_value;
    logic [RW-1:0]  i_radix;
    logic           o_strobe;
    logic [CHW-1:0] o_character;
    logic           o_is_last;
    logic [DCW-1:0] o_digit_count;

    int fail_count;
    int pending;

    // free-running 100 MHz clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    unsigned_to_radix_ascii i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .o_strobe     (o_strobe),
        .o_character  (o_character),
        .o_is_last    (o_is_last),
        .o_digit_count(o_digit_count)
    );

    // the checker does all prediction and comparison; we only read its counts
    digit_stream_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (start),
        .i_busy       (busy),
        .i_value      (i_value),
        .i_radix      (i_radix),
        .i_strobe     (o_strobe),
        .i_character  (o_character),
        .i_is_last    (o_is_last),
        .i_digit_count(o_digit_count),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // issue one conversion request and return at the edge that accepts it;
    // start is left high so a back-to-back request needs no extra edge
    task automatic send_request(input logic [VW-1:0] value,
                                input logic [RW-1:0] radix,
                                input bit            may_idle);
        int gap;
        if (may_idle && $urandom_range(99) < 14) begin
            // mostly short gaps, sometimes long ones so that the idle
            // request line lands on any point of the conversion
            gap     = ($urandom_range(3) == 0) ? $urandom_range(4, 120) : $urandom_range(1, 3);
            start   <= 1'b0;
            // junk on the data lines while start is low must be ignored
            i_value <= $urandom;
            i_radix <= RW'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        start   <= 1'b1;
        i_value <= value;
        i_radix <= radix;
        // busy read here is the value the dut saw at this edge
        do @(posedge i_clk); while (busy);
    endtask

    initial begin
        logic [VW-1:0] value;
        logic [RW-1:0] radix;
        logic [63:0]   power;
        int            shape;

        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_value <= '0;
        i_radix <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: zero value, field extremes, the longest and widest
        // digit strings, the digit/letter boundary and radix saturation
        send_request(32'd0, 6'd10, 1'b0);
        send_request(32'd0, 6'd2, 1'b0);
        send_request(32'd1, 6'd2, 1'b0);
        send_request(32'hFFFF_FFFF, 6'd2, 1'b0);
        send_request(32'h8000_0000, 6'd2, 1'b0);
        send_request(32'hFFFF_FFFF, 6'd3, 1'b0);
        send_request(32'hFFFF_FFFF, 6'd10, 1'b0);
        send_request(32'hFFFF_FFFF, 6'd16, 1'b0);
        send_request(32'hFFFF_FFFF, 6'd36, 1'b0);
        send_request(32'd9, 6'd10, 1'b0);
        send_request(32'd10, 6'd16, 1'b0);
        send_request(32'd35, 6'd36, 1'b0);
        send_request(32'd36, 6'd36, 1'b0);
        send_request(32'd1295, 6'd36, 1'b0);
        send_request(32'd2176782336, 6'd36, 1'b0);
        send_request(32'd100, 6'd10, 1'b0);
        send_request(32'd12345678, 6'd8, 1'b0);
        send_request(32'hDEAD_BEEF, 6'd16, 1'b0);
        // radix 0 and 1 act as binary, 37 and above act as base 36
        send_request(32'd5, 6'd0, 1'b0);
        send_request(32'd5, 6'd1, 1'b0);
        send_request(32'd1295, 6'd37, 1'b0);
        send_request(32'hFFFF_FFFF, 6'd63, 1'b0);
        send_request(32'd0, 6'd63, 1'b0);

        // random: mostly legal radix with values shaped to hit digit
        // count boundaries, some saturating radix codes mixed in
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            if ($urandom_range(99) < 12) begin
                radix = RW'($urandom_range(0, 63));
            end else begin
                radix = RW'($urandom_range(2, 36));
            end
            shape = $urandom_range(0, 4);
            case (shape)
                0: value = $urandom;
                1: value = $urandom_range(0, 2 * radix);
                2: begin
                    // near a power of the radix: digit count steps here
                    power = 64'd1;
                    repeat ($urandom_range(1, 31)) begin
                        if (power * radix <= 64'hFFFF_FFFF) begin
                            power = power * radix;
                        end
                    end
                    value = power[31:0] + 32'($urandom_range(0, 2)) - 32'd1;
                end
                3: value = 32'hFFFF_FFFF >> $urandom_range(0, 31);
                default: value = $urandom >> $urandom_range(0, 31);
            endcase
            // requests 70..119 go back to back with no idle cycles
            send_request(value, radix, !(n >= 70 && n < 120));
        end
        start <= 1'b0;

        // drain: let the last request show up in the pending count, then
        // wait for every digit and watch for strays
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

    // watchdog, far beyond the slowest legal run
    initial begin
        #8_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule
